// File: sv/blgh_pkg.sv
// ----------------------------------------------------------------------------
// Battery level gauge package
// Shared types, register codes and band constants of the battery level gauge.
// ----------------------------------------------------------------------------
package blgh_pkg;

    // Reading format
    localparam int unsigned ADC_W      = 12;
    localparam int unsigned HSUM_W     = 11;
    localparam int unsigned LSUM_W     = 7;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned LEVEL_W    = 3;
    localparam int unsigned CSEC_W     = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [IDX_W-1:0] SAMPLE_LAST = 3'd7;

    // Configuration reset values
    localparam logic [ADC_W-1:0]  HIGH_TH_RST      = 12'd1550;
    localparam logic [ADC_W-1:0]  LOW_TH_RST       = 12'd1150;
    localparam logic [CNT_W-1:0]  LOW_CONFIRM_RST  = 4'd10;
    localparam logic [CSEC_W-1:0] CHARGE_LIMIT_RST = 16'd600;

    // Offset bands
    localparam logic [ADC_W-1:0] OFS_FULL      = 12'd410;
    localparam logic [ADC_W-1:0] OFS_NEAR_FULL = 12'd350;
    localparam logic [ADC_W-1:0] OFS_UP6       = 12'd355;
    localparam logic [ADC_W-1:0] OFS_HOLD6     = 12'd396;
    localparam logic [ADC_W-1:0] OFS_PROMOTE   = 12'd395;
    localparam logic [ADC_W-1:0] OFS_B5        = 12'd325;
    localparam logic [ADC_W-1:0] OFS_B4        = 12'd260;
    localparam logic [ADC_W-1:0] OFS_B3        = 12'd200;
    localparam logic [ADC_W-1:0] OFS_B2        = 12'd100;
    localparam logic [ADC_W-1:0] OFS_DN5       = 12'd365;
    localparam logic [ADC_W-1:0] OFS_DN4       = 12'd320;
    localparam logic [ADC_W-1:0] OFS_DN3       = 12'd260;
    localparam logic [ADC_W-1:0] OFS_DN2       = 12'd190;
    localparam logic [ADC_W-1:0] OFS_DN1       = 12'd90;

    // Levels
    localparam logic [LEVEL_W-1:0] LEVEL_EMPTY  = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_1      = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_2      = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_3      = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_4      = 3'd4;
    localparam logic [LEVEL_W-1:0] LEVEL_5      = 3'd5;
    localparam logic [LEVEL_W-1:0] LEVEL_CHARGE = 3'd6;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL   = 3'd7;

    localparam logic [CSEC_W-1:0] CSEC_MAX = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_TH      = 2'd0,
        CFG_LOW_TH       = 2'd1,
        CFG_LOW_CONFIRM  = 2'd2,
        CFG_CHARGE_LIMIT = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_TICK   = 1'b1
    } item_mode_t;

    typedef struct packed {
        logic             mode;
        logic [ADC_W-1:0] adc_sample;
        logic             charging;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] battery_level;
        logic [ADC_W-1:0]   level_offset;
        logic               low_pending;
    } result_t;

    // Level and charge timer travelling to and from the band mapper
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [CSEC_W-1:0]  charge_seconds;
    } gauge_state_t;

endpackage

// File: sv/blgh_if.sv
// ----------------------------------------------------------------------------
// Battery level gauge channels
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface blgh_item_if
    import blgh_pkg::*;
();
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface blgh_result_if
    import blgh_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/battery_level_gauge_hysteresis_core.sv
// ----------------------------------------------------------------------------
// Battery level gauge with hysteresis
// Averages eight ADC samples into a reading, confirms low readings and maps
// the offset above the low threshold to a level with per-band hysteresis.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake     Contents
//  item      sink  valid/ready   mode, adc_sample, charging
//  result    src   valid/ready   battery_level, level_offset, low_pending
//  cfg       sink  cfg_wr_en     cfg_index, cfg_wdata (no read-back)
//
//  One item per cycle while no held result stalls evaluation; an item waits
//  in the input register, and its result is loaded into the output register.
//  The eighth sample of a reading gives a result; other items give none.
//  A held result stalls evaluation, and the input register then fills and
//  drops item.ready. Reset clears the valid flags and the gauge state and loads register defaults.
// ----------------------------------------------------------------------------
module battery_level_gauge_hysteresis_core
    import blgh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    blgh_item_if.sink             item,
    blgh_result_if.source         result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration
    logic [ADC_W-1:0]  high_th_reg;
    logic [ADC_W-1:0]  low_th_reg;
    logic [CNT_W-1:0]  low_confirm_reg;
    logic [CSEC_W-1:0] charge_limit_reg;

    // Input stage
    logic  in_vld_reg;
    item_t in_reg;

    // Gauge state
    logic [HSUM_W-1:0]  hsum_reg,  hsum_next;
    logic [LSUM_W-1:0]  lsum_reg,  lsum_next;
    logic [IDX_W-1:0]   idx_reg,   idx_next;
    logic [CNT_W-1:0]   lowcnt_reg, lowcnt_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [CSEC_W-1:0]  csec_reg,  csec_next;

    // Output stage
    logic    out_vld_reg;
    result_t out_reg, out_next;

    logic              fire;
    logic              last_sample;
    logic              produce;
    logic [CSEC_W-1:0] csec_base;
    logic [HSUM_W-1:0] hsum_add;
    logic [LSUM_W-1:0] lsum_add;
    logic [14:0]       reading_sum;
    logic [ADC_W-1:0]  reading;
    logic [CNT_W:0]    lowcnt_inc;
    logic [ADC_W-1:0]  offset;
    logic              pending;
    logic              confirmed;
    gauge_state_t      map_cur;
    gauge_state_t      map_nxt;

    // Handshake
    assign fire        = in_vld_reg && (!out_vld_reg || result.ready);
    assign item.ready  = !in_vld_reg || fire;
    assign result.valid   = out_vld_reg;
    assign result.payload = out_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_th_reg      <= HIGH_TH_RST;
            low_th_reg       <= LOW_TH_RST;
            low_confirm_reg  <= LOW_CONFIRM_RST;
            charge_limit_reg <= CHARGE_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_HIGH_TH:      high_th_reg      <= cfg_wdata[ADC_W-1:0];
                CFG_LOW_TH:       low_th_reg       <= cfg_wdata[ADC_W-1:0];
                CFG_LOW_CONFIRM:  low_confirm_reg  <= cfg_wdata[CNT_W-1:0];
                CFG_CHARGE_LIMIT: charge_limit_reg <= cfg_wdata[CSEC_W-1:0];
                default:          high_th_reg      <= high_th_reg;
            endcase
        end
    end

    // Capture the input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (item.ready)
            in_vld_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            in_reg <= item.payload;
    end

    // Accumulate and form the reading
    always_comb
    begin
        csec_base   = in_reg.charging ? csec_reg : '0;
        hsum_add    = hsum_reg + {3'b000, in_reg.adc_sample[ADC_W-1:4]};
        lsum_add    = lsum_reg + {3'b000, in_reg.adc_sample[3:0]};
        reading_sum = {hsum_add, 4'b0000} + {8'd0, lsum_add[LSUM_W-1:4], 4'b0000};
        reading     = reading_sum[14:3];
        last_sample = (idx_reg == SAMPLE_LAST);
        lowcnt_inc  = {1'b0, lowcnt_reg} + {{CNT_W{1'b0}}, 1'b1};
    end

    // Evaluate the reading against the thresholds
    always_comb
    begin
        offset      = '0;
        pending     = 1'b0;
        confirmed   = 1'b0;
        lowcnt_next = lowcnt_reg;
        priority if (reading > high_th_reg)
        begin
            lowcnt_next = '0;
            offset      = (reading >= low_th_reg) ? reading - low_th_reg : '0;
        end
        else if (reading < low_th_reg)
        begin
            if (lowcnt_inc < {1'b0, low_confirm_reg})
            begin
                lowcnt_next = lowcnt_inc[CNT_W-1:0];
                pending     = 1'b1;
            end
            else
            begin
                lowcnt_next = low_confirm_reg;
                confirmed   = 1'b1;
            end
        end
        else
        begin
            lowcnt_next = '0;
            offset      = reading - low_th_reg;
        end
    end

    assign map_cur.level          = confirmed ? LEVEL_EMPTY : level_reg;
    assign map_cur.charge_seconds = csec_base;

    blgh_level_map u_level_map (
        .offset       (offset),
        .charge_limit (charge_limit_reg),
        .state_cur    (map_cur),
        .state_nxt    (map_nxt)
    );

    // Next state per item kind
    always_comb
    begin
        hsum_next  = hsum_reg;
        lsum_next  = lsum_reg;
        idx_next   = idx_reg;
        level_next = level_reg;
        csec_next  = csec_base;
        produce    = 1'b0;
        out_next   = out_reg;
        unique case (item_mode_t'(in_reg.mode))
            MODE_TICK:
            begin
                if (in_reg.charging && level_reg == LEVEL_CHARGE && csec_base != CSEC_MAX)
                    csec_next = csec_base + 16'd1;
            end
            MODE_SAMPLE:
            begin
                if (!last_sample)
                begin
                    hsum_next = hsum_add;
                    lsum_next = lsum_add;
                    idx_next  = idx_reg + 3'd1;
                end
                else
                begin
                    hsum_next = '0;
                    lsum_next = '0;
                    idx_next  = '0;
                    produce   = 1'b1;
                    if (pending)
                    begin
                        level_next = level_reg;
                        csec_next  = csec_base;
                    end
                    else
                    begin
                        level_next = map_nxt.level;
                        csec_next  = map_nxt.charge_seconds;
                    end
                    out_next.battery_level = level_next;
                    out_next.level_offset  = offset;
                    out_next.low_pending   = pending;
                end
            end
            default:
            begin
                csec_next = csec_base;
            end
        endcase
    end

    // Advance gauge state on each evaluated item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsum_reg   <= '0;
            lsum_reg   <= '0;
            idx_reg    <= '0;
            lowcnt_reg <= '0;
            level_reg  <= LEVEL_EMPTY;
            csec_reg   <= '0;
        end
        else if (fire)
        begin
            hsum_reg  <= hsum_next;
            lsum_reg  <= lsum_next;
            idx_reg   <= idx_next;
            level_reg <= level_next;
            csec_reg  <= csec_next;
            if (in_reg.mode == MODE_SAMPLE && last_sample)
                lowcnt_reg <= lowcnt_next;
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (fire && produce)
            out_vld_reg <= 1'b1;
        else if (result.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && produce)
            out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fire && produce |=> out_vld_reg)
        else $error("result not loaded after a completed reading");

    a_pending_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.low_pending |-> out_reg.level_offset == '0)
        else $error("pending low result carries an offset");

    a_confirm_empty: assert property (@(posedge clk) disable iff (!rst_n)
        fire && produce && confirmed |=> level_reg == LEVEL_EMPTY)
        else $error("confirmed low did not empty the level");

    a_reading_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && produce |=> idx_reg == '0 && hsum_reg == '0 && lsum_reg == '0)
        else $error("sums not cleared after a reading");

    a_charge_at_six: assert property (@(posedge clk) disable iff (!rst_n)
        csec_reg > $past(csec_reg) |-> $past(level_reg) == LEVEL_CHARGE)
        else $error("charge timer advanced outside level six");
`endif

endmodule

// File: sv/blgh_level_map.sv
// ----------------------------------------------------------------------------
// Battery level band mapper
// Maps a nonzero reading offset to levels 1..7 with per-band hysteresis and updates
// the charge timer on the near-full and lower bands.
// ----------------------------------------------------------------------------
module blgh_level_map
    import blgh_pkg::*;
(
    input  logic [ADC_W-1:0]  offset,
    input  logic [CSEC_W-1:0] charge_limit,
    input  gauge_state_t      state_cur,
    output gauge_state_t      state_nxt
);

    logic [LEVEL_W-1:0] lvl;
    logic [CSEC_W-1:0]  csec;
    logic [LEVEL_W-1:0] near_full_lvl;

    assign lvl  = state_cur.level;
    assign csec = state_cur.charge_seconds;

    // Near-full band: step up to 6, drop from 7 to 6 only without charge time
    always_comb
    begin
        near_full_lvl = lvl;
        if (lvl < LEVEL_CHARGE)
        begin
            if (offset > OFS_UP6)
                near_full_lvl = LEVEL_CHARGE;
        end
        else if (csec == '0 && offset < OFS_HOLD6)
        begin
            near_full_lvl = LEVEL_CHARGE;
        end
    end

    // Select band from the top; a higher level stays until the drop threshold
    always_comb
    begin
        state_nxt = state_cur;
        priority if (offset >= OFS_FULL)
        begin
            state_nxt.level = LEVEL_FULL;
        end
        else if (offset > OFS_NEAR_FULL)
        begin
            state_nxt.level = near_full_lvl;
            if (csec != '0 && offset > OFS_PROMOTE && csec > charge_limit)
            begin
                state_nxt.charge_seconds = charge_limit;
                state_nxt.level          = LEVEL_FULL;
            end
        end
        else if (offset > OFS_B5)
        begin
            state_nxt.level = (lvl > LEVEL_5 && offset >= OFS_DN5) ? lvl : LEVEL_5;
            state_nxt.charge_seconds = '0;
        end
        else if (offset > OFS_B4)
        begin
            state_nxt.level = (lvl > LEVEL_4 && offset >= OFS_DN4) ? lvl : LEVEL_4;
            state_nxt.charge_seconds = '0;
        end
        else if (offset > OFS_B3)
        begin
            state_nxt.level = (lvl > LEVEL_3 && offset >= OFS_DN3) ? lvl : LEVEL_3;
            state_nxt.charge_seconds = '0;
        end
        else if (offset > OFS_B2)
        begin
            state_nxt.level = (lvl > LEVEL_2 && offset >= OFS_DN2) ? lvl : LEVEL_2;
            state_nxt.charge_seconds = '0;
        end
        else if (offset != '0)
        begin
            state_nxt.level = (lvl > LEVEL_1 && offset >= OFS_DN1) ? lvl : LEVEL_1;
            state_nxt.charge_seconds = '0;
        end
        else
        begin
            state_nxt = state_cur;
        end
    end

endmodule
